// ----- hw/rtl/djbp_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// djbp_pkg
// Shared widths, register indexes and result codes of the playout controller.
// ----------------------------------------------------------------------------
package djbp_pkg;

   localparam int TIME_W      = 48;
   localparam int SEQ_W       = 16;
   localparam int SLOT_W      = 7;
   localparam int STATUS_W    = 2;
   localparam int SKIP_W      = 8;
   localparam int TOL_W       = 18;
   localparam int SLOTCNT_W   = 8;
   localparam int WIN_W       = 6;
   localparam int STALE_W     = 20;
   localparam int CSR_DATA_W  = 20;
   localparam int CSR_IDX_W   = 2;

   localparam int MAX_SLOTS   = 128;
   localparam int MAX_WINDOW  = 32;
   localparam int TABLE_DEPTH = 256;
   localparam int TAB_AW      = 8;   // sequence number after reduction
   localparam int MOD_W       = 9;   // modulus, up to twice the slot count
   localparam int CNT_W       = 5;   // remainder steps, up to SEQ_W

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_TOLERANCE  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SLOT_COUNT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_LOST_WIN   = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_STALE      = 2'd3;

   // register reset values
   localparam logic [TOL_W-1:0]     TOL_RESET      = '0;
   localparam logic [SLOTCNT_W-1:0] SLOTCNT_RESET  = 8'd128;
   localparam logic [WIN_W-1:0]     WIN_RESET      = 6'd32;
   localparam logic [STALE_W-1:0]   STALE_RESET    = 20'd30000;

   // item kinds
   localparam logic ACT_ARRIVAL = 1'b0;
   localparam logic ACT_PLAY    = 1'b1;

   // result codes
   localparam logic [STATUS_W-1:0] ST_STORED   = 2'd0;
   localparam logic [STATUS_W-1:0] ST_PLAY     = 2'd1;
   localparam logic [STATUS_W-1:0] ST_UNDERRUN = 2'd2;
   localparam logic [STATUS_W-1:0] ST_SILENCE  = 2'd3;

endpackage : djbp_pkg
`default_nettype wire

// ----- hw/rtl/djbp_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// djbp_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module djbp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule : djbp_ram
`default_nettype wire

// ----- hw/rtl/deadline_jitter_buffer_playout.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// deadline_jitter_buffer_playout
// Playout controller of a jitter buffer: packet deadlines and slot choice.
// ----------------------------------------------------------------------------
// Items enter on the req_ channel (valid/ready): an arrival (action 0) with
// its sequence number, or a playout request (action 1), both stamped with
// now_us. Every item gives exactly one result beat on the rsp_ channel.
// The user must write registers over the csr_ port only while the block is
// idle; the block itself does not enforce it. One item is worked on at a
// time. The sequence number is reduced by a one-bit-per-cycle remainder
// unit, and a request scans the deadline RAM one read per cycle, over
// lost_window + 1 entries (lost_window above 32 counts as 32). A request
// before any arrival gives silence without a scan.
// A new item is taken as soon as the previous result sits in the output
// register; if the receiver stalls, the next result waits in the core until
// that register frees up. After reset the registers hold their defaults,
// no arrival is known and every deadline reads as zero (per-entry valid
// bits, no clearing pass needed).
// ----------------------------------------------------------------------------
module deadline_jitter_buffer_playout (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_ready,
   input  wire logic                              req_action,
   input  wire logic [djbp_pkg::SEQ_W-1:0]        req_seq_number,
   input  wire logic [djbp_pkg::TIME_W-1:0]       req_now_us,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_ready,
   output logic      [djbp_pkg::SLOT_W-1:0]       rsp_slot_index,
   output logic      [djbp_pkg::STATUS_W-1:0]     rsp_play_status,
   output logic      [djbp_pkg::SKIP_W-1:0]       rsp_skip_count,
   input  wire logic                              csr_wr_en,
   input  wire logic [djbp_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire logic [djbp_pkg::CSR_DATA_W-1:0]   csr_wr_data
);

   localparam int TW = djbp_pkg::TIME_W;
   localparam int AW = djbp_pkg::TAB_AW;
   localparam int MW = djbp_pkg::MOD_W;

   localparam logic [3:0] S_IDLE     = 4'd0;
   localparam logic [3:0] S_ARR_MOD  = 4'd1;
   localparam logic [3:0] S_ARR_WR   = 4'd2;
   localparam logic [3:0] S_NEW_MOD  = 4'd3;
   localparam logic [3:0] S_PLAY_MOD = 4'd4;
   localparam logic [3:0] S_WIN_MOD  = 4'd5;
   localparam logic [3:0] S_RD_PLAY  = 4'd6;
   localparam logic [3:0] S_SCAN     = 4'd7;
   localparam logic [3:0] S_STALE    = 4'd8;
   localparam logic [3:0] S_DONE     = 4'd9;

   // configuration
   logic [djbp_pkg::TOL_W-1:0]     tol_ff;
   logic [djbp_pkg::SLOTCNT_W-1:0] slot_cnt_ff;
   logic [djbp_pkg::WIN_W-1:0]     lost_win_ff;
   logic [djbp_pkg::STALE_W-1:0]   stale_ff;

   // control and item registers
   logic [3:0]                   state_ff, state_in;
   logic                         have_ff, have_in;
   logic [AW-1:0]                newest_ff, newest_in;
   logic [AW-1:0]                play_seq_ff, play_seq_in;
   logic [TW-1:0]                now_ff, now_in;
   logic [djbp_pkg::SEQ_W-1:0]   val_ff, val_in;
   logic [MW-1:0]                rem_ff, rem_in;
   logic [djbp_pkg::CNT_W-1:0]   cnt_ff, cnt_in;
   logic [AW-1:0]                newest_r_ff, newest_r_in;
   logic [AW-1:0]                play_ff, play_in;
   logic [AW-1:0]                next_ff, next_in;
   logic [djbp_pkg::WIN_W-1:0]   left_ff, left_in;
   logic [TW-1:0]                dp_ff, dp_in;
   logic                         ret_play_ff, ret_play_in;
   logic                         ret_scan_ff, ret_scan_in;
   logic [AW-1:0]                ret_addr_ff, ret_addr_in;
   logic                         ret_ok_ff, ret_ok_in;
   logic [djbp_pkg::TABLE_DEPTH-1:0] vld_ff;
   logic [djbp_pkg::SLOT_W-1:0]  res_slot_ff, res_slot_in;
   logic [djbp_pkg::STATUS_W-1:0] res_status_ff, res_status_in;
   logic [djbp_pkg::SKIP_W-1:0]  res_skip_ff, res_skip_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic [djbp_pkg::SLOT_W-1:0]  rsp_slot_ff;
   logic [djbp_pkg::STATUS_W-1:0] rsp_status_ff;
   logic [djbp_pkg::SKIP_W-1:0]  rsp_skip_ff;

   // derived values
   logic [djbp_pkg::SLOTCNT_W-1:0] slots;
   logic [MW-1:0]                  modulus;
   logic [djbp_pkg::WIN_W-1:0]     win_sat;
   logic [MW:0]                    mod_shift;
   logic [MW:0]                    mod_step;
   logic                           mod_last;
   logic [AW-1:0]                  mod_res;
   logic [MW-1:0]                  next_inc;
   logic [TW:0]                    dl_sum;
   logic [TW-1:0]                  deadline;
   logic [TW-1:0]                  dn;
   logic [TW-1:0]                  age;
   logic                           stale_hit;
   logic                           scan_take;
   logic                           scan_found;
   logic                           scan_last;
   logic                           accept;
   logic                           out_free;

   // RAM port
   logic                           ram_wr_en;
   logic                           ram_rd_en;
   logic [AW-1:0]                  ram_rd_addr;
   logic [TW-1:0]                  ram_rd_data;

   // (a - b) modulo m, with a and b already below m
   function automatic logic [AW-1:0] mod_sub(input logic [AW-1:0] a,
                                              input logic [AW-1:0] b,
                                              input logic [MW-1:0] m);
      logic [MW-1:0] t;
      begin
         if (a >= b) begin
            t = {1'b0, a} - {1'b0, b};
         end else begin
            t = {1'b0, a} + m - {1'b0, b};
         end
         return t[AW-1:0];
      end
   endfunction

   // x modulo the slot count, with x below twice the slot count
   function automatic logic [djbp_pkg::SLOT_W-1:0] slot_of(
         input logic [AW-1:0] x, input logic [djbp_pkg::SLOTCNT_W-1:0] s);
      logic [AW-1:0] t;
      begin
         if (x >= s) begin
            t = x - s;
         end else begin
            t = x;
         end
         return t[djbp_pkg::SLOT_W-1:0];
      end
   endfunction

   assign accept    = req_valid && req_ready;
   assign req_ready = (state_ff == S_IDLE);
   assign out_free  = !rsp_valid_ff || rsp_ready;

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_slot_index  = rsp_slot_ff;
   assign rsp_play_status = rsp_status_ff;
   assign rsp_skip_count  = rsp_skip_ff;

   always_comb begin
      if (slot_cnt_ff == '0) begin
         slots = 8'd1;
      end else if (slot_cnt_ff > 8'(djbp_pkg::MAX_SLOTS)) begin
         slots = 8'(djbp_pkg::MAX_SLOTS);
      end else begin
         slots = slot_cnt_ff;
      end
      if (lost_win_ff > 6'(djbp_pkg::MAX_WINDOW)) begin
         win_sat = 6'(djbp_pkg::MAX_WINDOW);
      end else begin
         win_sat = lost_win_ff;
      end
   end

   assign modulus = {slots, 1'b0};

   // restoring remainder, one dividend bit per cycle
   assign mod_shift = {rem_ff, val_ff[djbp_pkg::SEQ_W-1]};
   assign mod_step  = (mod_shift >= {1'b0, modulus}) ? (mod_shift - {1'b0, modulus})
                                                     : mod_shift;
   assign mod_res   = mod_step[AW-1:0];
   assign mod_last  = (cnt_ff == 5'd1);

   assign next_inc  = ({1'b0, next_ff} + 9'd1 == modulus) ? '0 : ({1'b0, next_ff} + 9'd1);

   // deadline saturates at the top of the time range
   assign dl_sum    = {1'b0, now_ff} + {{(TW + 1 - djbp_pkg::TOL_W){1'b0}}, tol_ff};
   assign deadline  = dl_sum[TW] ? '1 : dl_sum[TW-1:0];

   // entries never written read as zero
   assign dn         = ret_ok_ff ? ram_rd_data : '0;
   assign scan_take  = ret_scan_ff && !(dn < dp_ff);
   assign scan_found = scan_take && (dn > now_ff);
   assign scan_last  = ret_scan_ff && (left_ff == '0);

   assign age       = now_ff - dp_ff;
   assign stale_hit = (play_ff == newest_r_ff) && (now_ff > dp_ff)
                      && (age > {{(TW - djbp_pkg::STALE_W){1'b0}}, stale_ff});

   assign ram_wr_en   = (state_ff == S_ARR_WR);
   assign ram_rd_en   = (state_ff == S_RD_PLAY) || ((state_ff == S_SCAN) && (left_ff != '0));
   assign ram_rd_addr = (state_ff == S_RD_PLAY) ? play_ff : next_ff;

   djbp_ram #(
      .WIDTH (TW),
      .DEPTH (djbp_pkg::TABLE_DEPTH)
   ) u_deadline_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (newest_ff),
      .wr_data (deadline),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   always_comb begin
      state_in      = state_ff;
      have_in       = have_ff;
      newest_in     = newest_ff;
      play_seq_in   = play_seq_ff;
      now_in        = now_ff;
      val_in        = val_ff;
      rem_in        = rem_ff;
      cnt_in        = cnt_ff;
      newest_r_in   = newest_r_ff;
      play_in       = play_ff;
      next_in       = next_ff;
      left_in       = left_ff;
      dp_in         = dp_ff;
      res_slot_in   = res_slot_ff;
      res_status_in = res_status_ff;
      res_skip_in   = res_skip_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      ret_play_in   = (state_ff == S_RD_PLAY);
      ret_scan_in   = (state_ff == S_SCAN) && (left_ff != '0);
      ret_addr_in   = ram_rd_addr;
      ret_ok_in     = vld_ff[ram_rd_addr];

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               now_in = req_now_us;
               rem_in = '0;
               if (req_action == djbp_pkg::ACT_ARRIVAL) begin
                  val_in   = req_seq_number;
                  cnt_in   = 5'(djbp_pkg::SEQ_W);
                  state_in = S_ARR_MOD;
               end else if (!have_ff) begin
                  res_slot_in   = '0;
                  res_status_in = djbp_pkg::ST_SILENCE;
                  res_skip_in   = '0;
                  state_in      = S_DONE;
               end else begin
                  val_in   = {newest_ff, 8'd0};
                  cnt_in   = 5'(AW);
                  state_in = S_NEW_MOD;
               end
            end
         end
         S_ARR_MOD: begin
            rem_in = mod_step[MW-1:0];
            val_in = {val_ff[djbp_pkg::SEQ_W-2:0], 1'b0};
            cnt_in = cnt_ff - 5'd1;
            if (mod_last) begin
               newest_in = mod_res;
               state_in  = S_ARR_WR;
            end
         end
         S_ARR_WR: begin
            have_in       = 1'b1;
            res_slot_in   = slot_of(newest_ff, slots);
            res_status_in = djbp_pkg::ST_STORED;
            res_skip_in   = '0;
            state_in      = S_DONE;
         end
         S_NEW_MOD: begin
            rem_in = mod_step[MW-1:0];
            val_in = {val_ff[djbp_pkg::SEQ_W-2:0], 1'b0};
            cnt_in = cnt_ff - 5'd1;
            if (mod_last) begin
               newest_r_in = mod_res;
               rem_in      = '0;
               val_in      = {play_seq_ff + 8'd1, 8'd0};
               cnt_in      = 5'(AW);
               state_in    = S_PLAY_MOD;
            end
         end
         S_PLAY_MOD: begin
            rem_in = mod_step[MW-1:0];
            val_in = {val_ff[djbp_pkg::SEQ_W-2:0], 1'b0};
            cnt_in = cnt_ff - 5'd1;
            if (mod_last) begin
               play_in  = mod_res;
               rem_in   = '0;
               val_in   = {win_sat, {(djbp_pkg::SEQ_W - djbp_pkg::WIN_W){1'b0}}};
               cnt_in   = 5'(djbp_pkg::WIN_W);
               state_in = S_WIN_MOD;
            end
         end
         S_WIN_MOD: begin
            rem_in = mod_step[MW-1:0];
            val_in = {val_ff[djbp_pkg::SEQ_W-2:0], 1'b0};
            cnt_in = cnt_ff - 5'd1;
            if (mod_last) begin
               // scan starts lost_window numbers behind the newest arrival
               next_in  = mod_sub(newest_r_ff, mod_res, modulus);
               left_in  = win_sat + 6'd1;
               state_in = S_RD_PLAY;
            end
         end
         S_RD_PLAY: begin
            state_in = S_SCAN;
         end
         S_SCAN: begin
            if (left_ff != '0) begin
               next_in = next_inc[AW-1:0];
               left_in = left_ff - 6'd1;
            end
            if (ret_play_ff) begin
               dp_in = dn;
            end
            if (scan_take) begin
               play_in = ret_addr_ff;
               dp_in   = dn;
            end
            if (scan_found) begin
               play_seq_in   = ret_addr_ff;
               res_slot_in   = slot_of(ret_addr_ff, slots);
               res_status_in = djbp_pkg::ST_PLAY;
               res_skip_in   = mod_sub(ret_addr_ff, play_ff, modulus);
               state_in      = S_DONE;
            end else if (scan_last) begin
               state_in = S_STALE;
            end
         end
         S_STALE: begin
            play_seq_in   = play_ff;
            res_slot_in   = '0;
            res_skip_in   = '0;
            res_status_in = stale_hit ? djbp_pkg::ST_SILENCE : djbp_pkg::ST_UNDERRUN;
            state_in      = S_DONE;
         end
         S_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         have_ff      <= 1'b0;
         newest_ff    <= '0;
         play_seq_ff  <= '1;
         rsp_valid_ff <= 1'b0;
         ret_play_ff  <= 1'b0;
         ret_scan_ff  <= 1'b0;
         vld_ff       <= '0;
         tol_ff       <= djbp_pkg::TOL_RESET;
         slot_cnt_ff  <= djbp_pkg::SLOTCNT_RESET;
         lost_win_ff  <= djbp_pkg::WIN_RESET;
         stale_ff     <= djbp_pkg::STALE_RESET;
      end else begin
         state_ff     <= state_in;
         have_ff      <= have_in;
         newest_ff    <= newest_in;
         play_seq_ff  <= play_seq_in;
         rsp_valid_ff <= rsp_valid_in;
         ret_play_ff  <= ret_play_in;
         ret_scan_ff  <= ret_scan_in;
         if (ram_wr_en) begin
            vld_ff[newest_ff] <= 1'b1;
         end
         if (csr_wr_en) begin
            case (csr_index)
               djbp_pkg::CSR_TOLERANCE:  tol_ff      <= csr_wr_data[djbp_pkg::TOL_W-1:0];
               djbp_pkg::CSR_SLOT_COUNT: slot_cnt_ff <= csr_wr_data[djbp_pkg::SLOTCNT_W-1:0];
               djbp_pkg::CSR_LOST_WIN:   lost_win_ff <= csr_wr_data[djbp_pkg::WIN_W-1:0];
               djbp_pkg::CSR_STALE:      stale_ff    <= csr_wr_data[djbp_pkg::STALE_W-1:0];
               default: begin
               end
            endcase
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      now_ff        <= now_in;
      val_ff        <= val_in;
      rem_ff        <= rem_in;
      cnt_ff        <= cnt_in;
      newest_r_ff   <= newest_r_in;
      play_ff       <= play_in;
      next_ff       <= next_in;
      left_ff       <= left_in;
      dp_ff         <= dp_in;
      ret_addr_ff   <= ret_addr_in;
      ret_ok_ff     <= ret_ok_in;
      res_slot_ff   <= res_slot_in;
      res_status_ff <= res_status_in;
      res_skip_ff   <= res_skip_in;
      if ((state_ff == S_DONE) && out_free) begin
         rsp_slot_ff   <= res_slot_ff;
         rsp_status_ff <= res_status_ff;
         rsp_skip_ff   <= res_skip_ff;
      end
   end

endmodule : deadline_jitter_buffer_playout
`default_nettype wire

// ----- hw/rtl/djbp_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// djbp_checker
// Port-level checks of the playout controller, bound to the top level.
// ----------------------------------------------------------------------------
module djbp_checker (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            rsp_valid,
   input  wire logic                            rsp_ready,
   input  wire logic [djbp_pkg::SLOT_W-1:0]     rsp_slot_index,
   input  wire logic [djbp_pkg::STATUS_W-1:0]   rsp_play_status,
   input  wire logic [djbp_pkg::SKIP_W-1:0]     rsp_skip_count
);

   // a stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_slot_index)
                                  && $stable(rsp_play_status) && $stable(rsp_skip_count))
      else $error("result beat changed while stalled");

   // no result beat straight out of reset
   a_rsp_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result beat right after reset");

   // only a chosen packet reports skipped numbers
   a_skip_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_play_status != djbp_pkg::ST_PLAY) |-> rsp_skip_count == '0)
      else $error("skip count without a chosen packet");

   // underrun and silence carry no slot
   a_slot_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && ((rsp_play_status == djbp_pkg::ST_UNDERRUN)
                    || (rsp_play_status == djbp_pkg::ST_SILENCE)) |-> rsp_slot_index == '0)
      else $error("slot index on underrun or silence");

endmodule : djbp_checker

bind deadline_jitter_buffer_playout djbp_checker u_djbp_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_valid),
   .rsp_ready       (rsp_ready),
   .rsp_slot_index  (rsp_slot_index),
   .rsp_play_status (rsp_play_status),
   .rsp_skip_count  (rsp_skip_count)
);
`default_nettype wire
